>>> design/ecdf_pkg.sv
// Shared types and constants of the empirical CDF sorter.
package ecdf_pkg;

   // Fixed field widths of the items.
   localparam int SAMPLE_W = 32;
   localparam int RANK_W   = 6;
   localparam int FRAC_W   = 16;

   // Default capacity of the sorting chain.
   localparam int MAX_SAMPLES_DEFAULT = 64;

   // Controller states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Input item payload.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_payload_type;

   // Result item payload.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] point_value;
      logic [RANK_W-1:0]          rank;
      logic [FRAC_W-1:0]          fraction;
      logic                       dropped;
      logic                       last_point;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_en;
      logic div_run;
      logic emit_run;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close_accept;
      logic div_done;
      logic emit_done;
   } dp_status_type;

endpackage

>>> design/ecdf_stream_if.sv
// Valid/ready channel that carries one payload item per handshake.
interface ecdf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/ecdf_ctrl.sv
// Controller state machine: load, divide, emit.
module ecdf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  ecdf_pkg::dp_status_type  status,
   output ecdf_pkg::ctrl_cmd_type   cmd
);

   ecdf_pkg::state_type state_ff;
   ecdf_pkg::state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecdf_pkg::ST_LOAD: begin
            if (status.close_accept) state_in = ecdf_pkg::ST_DIVIDE;
         end
         ecdf_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = ecdf_pkg::ST_EMIT;
         end
         ecdf_pkg::ST_EMIT: begin
            if (status.emit_done) state_in = ecdf_pkg::ST_LOAD;
         end
         default: state_in = ecdf_pkg::ST_LOAD;
      endcase
   end

   // Commands decoded from the state.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ecdf_pkg::ST_LOAD:   cmd.accept_en = 1'b1;
         ecdf_pkg::ST_DIVIDE: cmd.div_run   = 1'b1;
         ecdf_pkg::ST_EMIT:   cmd.emit_run  = 1'b1;
         default:             cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecdf_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/ecdf_dpath.sv
// Datapath: sorted insertion chain, reciprocal divider, fraction accumulator, result register.
module ecdf_dpath #(
   parameter int MAX_SAMPLES = ecdf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ecdf_pkg::ctrl_cmd_type     cmd,
   output ecdf_pkg::dp_status_type    status,
   input  logic                       req_valid,
   input  ecdf_pkg::req_payload_type  req_payload,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output ecdf_pkg::rsp_payload_type  rsp_payload
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int REM_W  = CNT_W + 1;
   localparam int SUM_W  = REM_W + 1;
   localparam int QUO_W  = ecdf_pkg::FRAC_W + 1;
   localparam int STEP_W = $clog2(QUO_W);
   localparam int SW     = ecdf_pkg::SAMPLE_W;

   // Sorted cell chain and set bookkeeping.
   logic signed [SW-1:0] cell_ff [MAX_SAMPLES];
   logic signed [SW-1:0] cell_in [MAX_SAMPLES];
   logic signed [SW-1:0] ins_val [MAX_SAMPLES];
   logic signed [SW-1:0] shf_val [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] less;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic signed [SW-1:0] max_ff, max_in;

   // Divider for 65536 / n.
   logic [REM_W-1:0]  rem_ff, rem_in, rem_shift;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Emission walk and fraction accumulator.
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [QUO_W-1:0]     acc_q_ff, acc_q_in;
   logic [REM_W-1:0]     acc_r_ff, acc_r_in;
   logic [SUM_W-1:0]     r_sum;
   logic                 r_wrap;
   logic signed [SW-1:0] prev_ff, prev_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ecdf_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic signed [SW-1:0] new_sample;
   logic signed [SW-1:0] head;
   logic accept, room, insert, close;
   logic distinct, out_free, emit_step, emit_done, div_done;

   assign new_sample = req_payload.sample;
   assign accept     = req_valid && cmd.accept_en;
   assign room       = cnt_ff < CNT_W'(MAX_SAMPLES);
   assign insert     = accept && room;
   assign close      = accept && req_payload.last_sample;

   // Each cell compares the new sample with its own value; empty cells act as infinity.
   genvar g;
   generate
      for (g = 0; g < MAX_SAMPLES; g++) begin : g_cell
         assign less[g] = (CNT_W'(g) >= cnt_ff) || (new_sample < cell_ff[g]);
         if (g == 0) begin : g_head
            assign ins_val[g] = less[g] ? new_sample : cell_ff[g];
         end else begin : g_body
            assign ins_val[g] = less[g] ? (less[g-1] ? cell_ff[g-1] : new_sample)
                                        : cell_ff[g];
         end
         if (g == MAX_SAMPLES - 1) begin : g_tail
            assign shf_val[g] = cell_ff[g];
         end else begin : g_link
            assign shf_val[g] = cell_ff[g+1];
         end
         assign cell_in[g] = insert ? ins_val[g] : (emit_step ? shf_val[g] : cell_ff[g]);
      end
   endgenerate

   // Track the largest stored value so the final distinct point can be flagged.
   always_comb begin
      max_in = max_ff;
      if (insert && ((cnt_ff == '0) || !(new_sample < max_ff))) max_in = new_sample;
   end

   // Restoring division, one quotient bit per cycle; the dividend is a one followed by zeros.
   assign rem_shift = {rem_ff[REM_W-2:0], (step_ff == '0)};
   assign div_done  = cmd.div_run && (step_ff == STEP_W'(QUO_W - 1));

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (close) begin
         rem_in  = '0;
         quo_in  = '0;
         step_in = '0;
      end else if (cmd.div_run) begin
         step_in = step_ff + STEP_W'(1);
         if (rem_shift >= REM_W'(cnt_ff)) begin
            rem_in = rem_shift - REM_W'(cnt_ff);
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // Emission: the head of the chain is the next sorted sample.
   assign head      = cell_ff[0];
   assign distinct  = (idx_ff == '0) || (head != prev_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_step = cmd.emit_run && (out_free || !distinct);
   assign emit_done = emit_step && (idx_ff == (cnt_ff - CNT_W'(1)));

   // The fraction advances by 65536/n per sorted position, carrying the remainder.
   assign r_sum  = SUM_W'(acc_r_ff) + SUM_W'(rem_ff);
   assign r_wrap = r_sum >= SUM_W'(cnt_ff);

   always_comb begin
      idx_in   = idx_ff;
      acc_q_in = acc_q_ff;
      acc_r_in = acc_r_ff;
      prev_in  = prev_ff;
      if (close) begin
         idx_in   = '0;
         acc_q_in = '0;
         acc_r_in = '0;
      end else if (emit_step) begin
         idx_in   = idx_ff + CNT_W'(1);
         acc_q_in = acc_q_ff + quo_ff + QUO_W'(r_wrap);
         acc_r_in = r_wrap ? REM_W'(r_sum - SUM_W'(cnt_ff)) : REM_W'(r_sum);
         prev_in  = head;
      end
   end

   // Set count and overflow flag.
   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (insert) cnt_in = cnt_ff + CNT_W'(1);
      if (accept && !room) ovf_in = 1'b1;
      if (emit_done) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   // Result register: loaded on a distinct value, held until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit_step && distinct) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.point_value = head;
         rsp_data_in.rank        = ecdf_pkg::RANK_W'(idx_ff);
         rsp_data_in.fraction    = acc_q_ff[ecdf_pkg::FRAC_W-1:0];
         rsp_data_in.dropped     = ovf_ff;
         rsp_data_in.last_point  = (head == max_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      max_ff      <= max_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      acc_q_ff    <= acc_q_in;
      acc_r_ff    <= acc_r_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.close_accept = close;
   assign status.div_done     = div_done;
   assign status.emit_done    = emit_done;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload         = rsp_data_ff;

endmodule

>>> design/empirical_cdf_sorter.sv
// Top level of the empirical CDF sorter: controller plus datapath.
//
//   Channel   Direction  Payload
//   req_chan  in         sample (s32 Q16.16), last_sample
//   rsp_chan  out        point_value, rank, fraction, dropped, last_point
//
// Each sample item is taken on its handshake and inserted into the sorted cell chain
// while there is room; otherwise it is dropped and the set is flagged. After the closing
// item a serial divider computes 65536/n. Emission then walks the chain one stored sample
// per cycle; a distinct value waits only while the result register is still full.
// Synchronous active-high reset empties the set; no input is taken during division and emission.
module empirical_cdf_sorter #(
   parameter int MAX_SAMPLES = ecdf_pkg::MAX_SAMPLES_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   ecdf_stream_if.sink   req_chan,
   ecdf_stream_if.source rsp_chan
);

   ecdf_pkg::ctrl_cmd_type  cmd;
   ecdf_pkg::dp_status_type status;

   // Sequencing of the load, divide and emit phases.
   ecdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Storage, sorting and result generation.
   ecdf_dpath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_valid   (req_chan.valid),
      .req_payload (req_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload)
   );

   assign req_chan.ready = cmd.accept_en;

endmodule

>>> design/ecdf_checker.sv
// Port-level assertions for the empirical CDF sorter, bound to the top level.
module ecdf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input ecdf_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ecdf_pkg::rsp_payload_type rsp_payload
);

   // A stalled result item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // Closing a set starts the division, so the next cycle takes no item.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_sample |=> !req_ready)
      else $error("input taken right after the closing item");

   // The first sorted position always has fraction zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.rank == '0) |-> (rsp_payload.fraction == '0))
      else $error("rank zero with nonzero fraction");

   // While more points of the set remain, no new sample is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_point |-> !req_ready)
      else $error("input taken during emission");

endmodule

bind empirical_cdf_sorter ecdf_checker u_ecdf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

>>> dv/ecdf_checker.sv
// Scoreboard for the empirical CDF sorter: predicts the points of each sample set and checks them.
module ecdf_scoreboard #(
   parameter int CAPACITY = ecdf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  ecdf_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ecdf_pkg::rsp_payload_type rsp_payload,
   output int                        fail_count,
   output int                        points_pending,
   output int                        points_checked,
   output int                        sets_closed,
   output int                        overflow_sets
);

   // Copy of the set being loaded, as the block holds it.
   logic signed [ecdf_pkg::SAMPLE_W-1:0] held_values [CAPACITY];
   int unsigned                          held_count;
   bit                                   lost_any;

   // Points predicted but not yet seen on the result channel.
   ecdf_pkg::rsp_payload_type expected_points [$];

   // Sorts the held set and queues one point per distinct value.
   task automatic build_points();
      logic signed [ecdf_pkg::SAMPLE_W-1:0] ordered [CAPACITY];
      logic signed [ecdf_pkg::SAMPLE_W-1:0] v;
      ecdf_pkg::rsp_payload_type            pt;
      ecdf_pkg::rsp_payload_type            set_points [$];
      int                                   j;

      // Insertion sort in signed order.
      for (int i = 0; i < int'(held_count); i++) begin
         v = held_values[i];
         j = i;
         while (j > 0 && v < ordered[j-1]) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = v;
      end

      // A point starts wherever the sorted value changes.
      for (int i = 0; i < int'(held_count); i++) begin
         if (i == 0 || ordered[i] != ordered[i-1]) begin
            pt.point_value = ordered[i];
            pt.rank        = ecdf_pkg::RANK_W'(i);
            pt.fraction    = ecdf_pkg::FRAC_W'((longint'(i) << 16) / longint'(held_count));
            pt.dropped     = lost_any;
            pt.last_point  = 1'b0;
            set_points.push_back(pt);
         end
      end

      for (int k = 0; k < set_points.size(); k++) begin
         pt = set_points[k];
         pt.last_point = (k == set_points.size() - 1);
         expected_points.push_back(pt);
      end
   endtask

   task automatic compare_field(string field_name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Watch both channels at every rising edge.
   always @(posedge clock) begin
      ecdf_pkg::rsp_payload_type want;

      if (reset) begin
         held_count     = 0;
         lost_any       = 1'b0;
         expected_points.delete();
         fail_count     = 0;
         points_checked = 0;
         sets_closed    = 0;
         overflow_sets  = 0;
      end else begin
         // Each accepted point is checked against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected point: value 0x%0h rank %0d",
                      rsp_payload.point_value, rsp_payload.rank);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               compare_field("point_value", want.point_value, rsp_payload.point_value);
               compare_field("rank", want.rank, rsp_payload.rank);
               compare_field("fraction", want.fraction, rsp_payload.fraction);
               compare_field("dropped", want.dropped, rsp_payload.dropped);
               compare_field("last_point", want.last_point, rsp_payload.last_point);
               points_checked++;
            end
         end

         // An accepted sample is stored while there is room, otherwise it is lost.
         if (req_valid && req_ready) begin
            if (held_count < CAPACITY) begin
               held_values[held_count] = req_payload.sample;
               held_count++;
            end else begin
               lost_any = 1'b1;
            end
            if (req_payload.last_sample) begin
               build_points();
               sets_closed++;
               if (lost_any) overflow_sets++;
               held_count = 0;
               lost_any   = 1'b0;
            end
         end
      end
      points_pending = expected_points.size();
   end

endmodule

>>> dv/tb.sv
// Top of the empirical CDF sorter testbench: clock, reset, sample stimulus and verdict.
module tb;

   localparam int CAPACITY      = ecdf_pkg::MAX_SAMPLES_DEFAULT;
   localparam int SAMPLE_GOAL   = 400;
   localparam int CALM_TAIL     = 60;
   localparam int PRESSURE_AT   = 40;
   localparam int PRESSURE_HOLD = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 200000;

   // Values that stress signed order, sign bits and duplicates.
   localparam logic [ecdf_pkg::SAMPLE_W-1:0] VALUE_POOL [8] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001
   };

   logic clock;
   logic reset;

   int accepted_items;
   int set_count;
   bit calm;
   bit pressure_done;
   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;

   int fail_count;
   int points_pending;
   int points_checked;
   int sets_closed;
   int overflow_sets;

   ecdf_stream_if #(.payload_type(ecdf_pkg::req_payload_type)) req_chan ();
   ecdf_stream_if #(.payload_type(ecdf_pkg::rsp_payload_type)) rsp_chan ();

   empirical_cdf_sorter #(
      .MAX_SAMPLES(CAPACITY)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   ecdf_scoreboard #(
      .CAPACITY(CAPACITY)
   ) u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_payload   (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_payload   (rsp_chan.payload),
      .fail_count    (fail_count),
      .points_pending(points_pending),
      .points_checked(points_checked),
      .sets_closed   (sets_closed),
      .overflow_sets (overflow_sets)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d points outstanding", cycle_count,
               points_pending);
      $display("Verification failed");
      $finish;
   end

   // Offers one sample item, optionally after an idle burst, and waits for its handshake.
   task automatic offer_item(logic [ecdf_pkg::SAMPLE_W-1:0] value, bit closing);
      ecdf_pkg::req_payload_type item;

      if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      item.sample      = value;
      item.last_sample = closing;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      accepted_items++;
   endtask

   // Mix of full-range, extreme, small and integer-valued samples.
   function automatic logic [ecdf_pkg::SAMPLE_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return VALUE_POOL[$urandom_range(0, 7)];
         3: return ecdf_pkg::SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
         default: return {16'($urandom_range(0, 65535) & 16'h800F), 16'h0000};
      endcase
   endfunction

   // Mostly small sets; the first two fill and overflow the store, a few more land near it on either side.
   function automatic int pick_set_size(int set_idx);
      if (set_idx == 0) return CAPACITY;
      if (set_idx == 1) return CAPACITY + 1;
      if ($urandom_range(0, 11) == 0) return $urandom_range(CAPACITY - 4, CAPACITY + 6);
      return $urandom_range(1, 12);
   endfunction

   // New idling densities, so that some sets run with no gaps at all.
   task automatic shuffle_idling();
      case ($urandom_range(0, 2))
         0: send_idle_pct = 0;
         1: send_idle_pct = 10;
         default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
         0: recv_stall_pct = 0;
         1: recv_stall_pct = 8;
         default: recv_stall_pct = 35;
      endcase
   endtask

   // Result side: random stall bursts and one long hold-off that backs up the input.
   initial begin
      int hold;

      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!pressure_done && accepted_items >= PRESSURE_AT) begin
            rsp_chan.ready <= 1'b0;
            hold = 0;
            while (hold < PRESSURE_HOLD) begin
               @(posedge clock);
               hold++;
            end
            pressure_done = 1'b1;
         end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Sample side: reset, directed sets, random sets, then drain and verdict.
   initial begin
      int set_size;
      int random_items;

      accepted_items   = 0;
      set_count        = 0;
      calm             = 1'b0;
      pressure_done    = 1'b0;
      send_idle_pct    = 20;
      recv_stall_pct   = 20;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Single sample at the most negative value.
      offer_item(32'h8000_0000, 1'b1);
      // Extremes of both signs around zero.
      offer_item(32'h7FFF_FFFF, 1'b0);
      offer_item(32'h8000_0000, 1'b0);
      offer_item(32'h0000_0000, 1'b0);
      offer_item(32'hFFFF_FFFF, 1'b0);
      offer_item(32'h0000_0001, 1'b1);
      // All samples equal: a single point.
      offer_item(32'h0005_0000, 1'b0);
      offer_item(32'h0005_0000, 1'b0);
      offer_item(32'h0005_0000, 1'b1);
      // Interleaved duplicates, so ranks skip.
      offer_item(32'h0000_0003, 1'b0);
      offer_item(32'hFFFF_FFFD, 1'b0);
      offer_item(32'h0000_0003, 1'b0);
      offer_item(32'hFFFF_FFFD, 1'b0);
      offer_item(32'h0000_0007, 1'b1);
      // Largest value twice.
      offer_item(32'h7FFF_FFFF, 1'b0);
      offer_item(32'h7FFF_FFFF, 1'b1);
      // Alternating bit patterns.
      offer_item(32'h5555_5555, 1'b0);
      offer_item(32'hAAAA_AAAA, 1'b1);
      set_count = 6;

      // Random sets until the sample budget is used up; the tail runs without idling.
      random_items = 0;
      while (accepted_items < SAMPLE_GOAL) begin
         set_size = pick_set_size(set_count - 6);
         shuffle_idling();
         for (int k = 0; k < set_size; k++) begin
            calm = (accepted_items >= SAMPLE_GOAL - CALM_TAIL);
            offer_item(pick_value(), k == set_size - 1);
            random_items++;
         end
         set_count++;
      end
      req_chan.valid <= 1'b0;

      // Let the last prediction land, then wait for every point and a short drain.
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d samples (%0d random) in %0d sets, %0d of them overflowing.",
               accepted_items, random_items, sets_closed, overflow_sets);
      $display("%0d distribution points checked, %0d mismatches.", points_checked, fail_count);
      if (fail_count == 0 && points_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
